[rtl/core/armacc_pkg.sv]
// ----------------------------------------------------------------------------
// armacc_pkg
// Shared constants, types and helpers for the audio ring mix accumulator.
// ----------------------------------------------------------------------------
package armacc_pkg;

  localparam int DEPTH = 4096;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int LEN_W = $clog2(DEPTH + 1);
  localparam int OFFSET_W = 12;
  localparam int SAMPLE_W = 32;
  localparam int CFG_LEN_W = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W = 2;
  localparam int SUM_W = ((ADDR_W > OFFSET_W) ? ADDR_W : OFFSET_W) + 1;
  localparam int MOD_CMP_W = (SUM_W > LEN_W) ? SUM_W : LEN_W;
  localparam int CNT_W = $clog2(SUM_W + 1);

  localparam logic [1:0] WCODE_8 = 2'd0;
  localparam logic [1:0] WCODE_16 = 2'd1;
  localparam logic [1:0] WCODE_32 = 2'd2;
  localparam logic [1:0] WCODE_NONE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LEN = 2'd1;

  localparam logic [1:0] WIDTH_RST = WCODE_16;
  localparam logic [CFG_LEN_W-1:0] RING_LEN_RST = 13'd4096;

  typedef struct packed {
    logic start;
    logic [SUM_W-1:0] dividend;
    logic [LEN_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic done;
    logic [ADDR_W-1:0] rem;
  } mod_rsp_t;

  typedef struct packed {
    logic start;
    logic [1:0] wcode;
    logic [SAMPLE_W-1:0] a;
    logic [SAMPLE_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic [SAMPLE_W-1:0] c;
  } alu_rsp_t;

  function automatic logic signed [SAMPLE_W-1:0] sext_word(logic [SAMPLE_W-1:0] v,
                                                          logic [1:0] wcode);
    logic signed [SAMPLE_W-1:0] r;
    case (wcode)
      WCODE_8: r = $signed({{24{v[7]}}, v[7:0]});
      WCODE_16: r = $signed({{16{v[15]}}, v[15:0]});
      default: r = $signed(v);
    endcase
    return r;
  endfunction

endpackage

[rtl/core/armacc_mod_unit.sv]
// ----------------------------------------------------------------------------
// armacc_mod_unit
// Iterative remainder unit: one restoring subtract step per cycle, with a
// direct answer and no steps when the dividend is already below the divisor.
// ----------------------------------------------------------------------------
module armacc_mod_unit
  import armacc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mod_req_t req,
  output mod_rsp_t rsp
);

  logic                 busy_r;
  logic                 done_r;
  logic [SUM_W-1:0]     q_r;
  logic [LEN_W-1:0]     div_r;
  logic [LEN_W-1:0]     rem_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [ADDR_W-1:0]    res_r;
  logic [LEN_W:0]       trial;
  logic [LEN_W-1:0]     rem_nxt;

  always_comb begin
    trial = {rem_r, q_r[SUM_W-1]};
    if (trial >= {1'b0, div_r}) begin
      rem_nxt = LEN_W'(trial - {1'b0, div_r});
    end else begin
      rem_nxt = LEN_W'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r && req.start) begin
        if (MOD_CMP_W'(req.dividend) < MOD_CMP_W'(req.divisor)) begin
          res_r  <= ADDR_W'(req.dividend);
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
          q_r    <= req.dividend;
          div_r  <= req.divisor;
          rem_r  <= '0;
          cnt_r  <= CNT_W'(SUM_W);
        end
      end else if (busy_r) begin
        q_r   <= {q_r[SUM_W-2:0], 1'b0};
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          res_r  <= ADDR_W'(rem_nxt);
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = res_r;

endmodule

[rtl/core/armacc_mix_alu.sv]
// ----------------------------------------------------------------------------
// armacc_mix_alu
// Three-stage mixing unit: sign extend, multiply, then combine A + B minus
// the shifted product and saturate for the selected sample width.
// ----------------------------------------------------------------------------
module armacc_mix_alu
  import armacc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  localparam int C_W = 35;
  localparam int PROD_W = 2 * SAMPLE_W;

  localparam logic signed [C_W-1:0] MAX8 = 35'sd127;
  localparam logic signed [C_W-1:0] MIN8 = -35'sd128;
  localparam logic signed [C_W-1:0] MAX16 = 35'sd32767;
  localparam logic signed [C_W-1:0] MIN16 = -35'sd32768;
  localparam logic signed [C_W-1:0] CLIP16_HI = 35'sd32750;
  localparam logic signed [C_W-1:0] CLIP16_LO = -35'sd32750;
  localparam logic signed [C_W-1:0] MAX32 = 35'sd2147483647;
  localparam logic signed [C_W-1:0] MIN32 = -35'sd2147483648;

  logic                        s1_vld_r;
  logic                        s2_vld_r;
  logic                        s3_vld_r;
  logic [1:0]                  w1_r;
  logic [1:0]                  w2_r;
  logic signed [SAMPLE_W-1:0]  a1_r;
  logic signed [SAMPLE_W-1:0]  b1_r;
  logic signed [C_W-1:0]       sum2_r;
  logic signed [PROD_W-1:0]    prod2_r;
  logic [SAMPLE_W-1:0]         c3_r;
  logic signed [PROD_W-1:0]    shifted;
  logic signed [C_W-1:0]       c_raw;
  logic signed [C_W-1:0]       c_sat;

  always_comb begin
    case (w2_r)
      WCODE_8: shifted = prod2_r >>> 8;
      WCODE_16: shifted = prod2_r >>> 16;
      default: shifted = prod2_r >>> 32;
    endcase
    c_raw = sum2_r - $signed(shifted[C_W-1:0]);
    c_sat = c_raw;
    case (w2_r)
      WCODE_8: begin
        if (c_raw > MAX8) begin
          c_sat = MAX8;
        end else if (c_raw < MIN8) begin
          c_sat = MIN8;
        end
      end
      WCODE_16: begin
        if (c_raw > MAX16) begin
          c_sat = CLIP16_HI;
        end else if (c_raw < MIN16) begin
          c_sat = CLIP16_LO;
        end
      end
      default: begin
        if (c_raw > MAX32) begin
          c_sat = MAX32;
        end else if (c_raw < MIN32) begin
          c_sat = MIN32;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= req.start;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    a1_r    <= sext_word(req.a, req.wcode);
    b1_r    <= sext_word(req.b, req.wcode);
    w1_r    <= req.wcode;
    w2_r    <= w1_r;
    sum2_r  <= C_W'(a1_r) + C_W'(b1_r);
    prod2_r <= a1_r * b1_r;
    c3_r    <= c_sat[SAMPLE_W-1:0];
  end

  assign rsp.done = s3_vld_r;
  assign rsp.c    = c3_r;

endmodule

[rtl/core/audio_ring_mix_accumulator_top.sv]
// ----------------------------------------------------------------------------
// audio_ring_mix_accumulator_top
// Ring store of signed samples with mix-in and read-out-and-clear words.
//
// A word is taken when start is high and busy is low. A mix word (in_op 0)
// combines in_sample into the slot at the read pointer plus in_offset and
// gives no result. A read word (in_op 1) returns the slot at the read
// pointer on out_sample with out_valid high for one cycle, clears the slot
// and advances the pointer. The receiver cannot stall; every strobe counts.
// A read word passes through S_RP, S_RD_ISSUE and S_RD_DATA; its result is
// registered in S_RD_DATA. A mix word's busy time is set by the memory read,
// the 3-stage multiplier path and the write back. Each position that wraps
// past the ring length adds the remainder unit's 13 one-bit steps (SUM_W
// steps). After reset a clearing pass writes zero to all 4096 slots, one per
// cycle, with busy high throughout. The cfg channel is always ready; index 0
// sets the sample width and index 1 the ring length; other indexes are
// ignored. Write it only while busy is low and no result is pending.
// ----------------------------------------------------------------------------
module audio_ring_mix_accumulator_top
  import armacc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_op,
  input  logic [OFFSET_W-1:0]   in_offset,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  output logic                  out_valid,
  output logic signed [SAMPLE_W-1:0] out_sample,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam logic [3:0] S_CLEAR     = 4'd0;
  localparam logic [3:0] S_IDLE      = 4'd1;
  localparam logic [3:0] S_RP        = 4'd2;
  localparam logic [3:0] S_POS       = 4'd3;
  localparam logic [3:0] S_RD_ISSUE  = 4'd4;
  localparam logic [3:0] S_RD_DATA   = 4'd5;
  localparam logic [3:0] S_MIX_ISSUE = 4'd6;
  localparam logic [3:0] S_MIX_DATA  = 4'd7;
  localparam logic [3:0] S_MIX_ALU   = 4'd8;

  localparam int LCMP_W = (LEN_W > CFG_LEN_W) ? LEN_W : CFG_LEN_W;

  logic [3:0]           state_r;
  logic [3:0]           state_nxt;
  logic [ADDR_W-1:0]    clr_addr_r;
  logic [1:0]           width_r;
  logic [CFG_LEN_W-1:0] ring_len_r;
  logic [ADDR_W-1:0]    read_pointer_r;
  logic [ADDR_W-1:0]    rp_r;
  logic [ADDR_W-1:0]    pos_r;
  logic                 op_r;
  logic [OFFSET_W-1:0]  offset_r;
  logic [SAMPLE_W-1:0]  sample_r;
  logic                 out_valid_r;
  logic [SAMPLE_W-1:0]  out_sample_r;
  logic [SAMPLE_W-1:0]  rd_data_r;
  logic [SAMPLE_W-1:0]  mem [DEPTH];

  logic [LCMP_W-1:0]    len_ext;
  logic [LEN_W-1:0]     eff_len;
  logic [LEN_W-1:0]     rp_inc;
  logic                 accept;
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_addr;
  logic [SAMPLE_W-1:0]  mem_wdata;
  mod_req_t             mod_req;
  mod_rsp_t             mod_rsp;
  alu_req_t             alu_req;
  alu_rsp_t             alu_rsp;

  armacc_mod_unit u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  armacc_mix_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .rsp   (alu_rsp)
  );

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign out_valid  = out_valid_r;
  assign out_sample = $signed(out_sample_r);

  always_comb begin
    len_ext = LCMP_W'(ring_len_r);
    if (len_ext == '0) begin
      eff_len = LEN_W'(1);
    end else if (len_ext > LCMP_W'(DEPTH)) begin
      eff_len = LEN_W'(DEPTH);
    end else begin
      eff_len = LEN_W'(len_ext);
    end
    rp_inc = LEN_W'(rp_r) + 1'b1;
  end

  always_comb begin
    state_nxt        = state_r;
    mod_req.start    = 1'b0;
    mod_req.dividend = SUM_W'(read_pointer_r);
    mod_req.divisor  = eff_len;
    alu_req.start    = 1'b0;
    alu_req.wcode    = width_r;
    alu_req.a        = rd_data_r;
    alu_req.b        = sample_r;
    mem_we           = 1'b0;
    mem_addr         = rp_r;
    mem_wdata        = '0;
    case (state_r)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_addr_r;
        if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          mod_req.start = 1'b1;
          state_nxt     = S_RP;
        end
      end
      S_RP: begin
        if (mod_rsp.done) begin
          if (op_r) begin
            state_nxt = S_RD_ISSUE;
          end else if (width_r == WCODE_NONE) begin
            state_nxt = S_IDLE;
          end else begin
            mod_req.start    = 1'b1;
            mod_req.dividend = SUM_W'(mod_rsp.rem) + SUM_W'(offset_r);
            state_nxt        = S_POS;
          end
        end
      end
      S_POS: begin
        if (mod_rsp.done) begin
          state_nxt = S_MIX_ISSUE;
        end
      end
      S_RD_ISSUE: begin
        state_nxt = S_RD_DATA;
      end
      S_RD_DATA: begin
        mem_we    = 1'b1;
        state_nxt = S_IDLE;
      end
      S_MIX_ISSUE: begin
        mem_addr  = pos_r;
        state_nxt = S_MIX_DATA;
      end
      S_MIX_DATA: begin
        mem_addr      = pos_r;
        alu_req.start = 1'b1;
        state_nxt     = S_MIX_ALU;
      end
      S_MIX_ALU: begin
        mem_addr = pos_r;
        if (alu_rsp.done) begin
          mem_we    = 1'b1;
          mem_wdata = alu_rsp.c;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_CLEAR;
      clr_addr_r     <= '0;
      width_r        <= WIDTH_RST;
      ring_len_r     <= RING_LEN_RST;
      read_pointer_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_RD_DATA);
      if (state_r == S_CLEAR) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_IDX_WIDTH) begin
          width_r <= cfg_wdata[1:0];
        end else if (cfg_index == CFG_IDX_LEN) begin
          ring_len_r <= cfg_wdata;
        end
      end
      if (state_r == S_RD_DATA) begin
        if (rp_inc == eff_len) begin
          read_pointer_r <= '0;
        end else begin
          read_pointer_r <= ADDR_W'(rp_inc);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_op;
      offset_r <= in_offset;
      sample_r <= in_sample;
    end
    if (state_r == S_RP && mod_rsp.done) begin
      rp_r <= mod_rsp.rem;
    end
    if (state_r == S_POS && mod_rsp.done) begin
      pos_r <= mod_rsp.rem;
    end
    if (state_r == S_RD_DATA) begin
      out_sample_r <= sext_word(rd_data_r, width_r);
    end
  end

  a_out_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r) == S_RD_DATA)
    else $error("result strobe without a read word");

  a_mod_done_owned: assert property (@(posedge clk) disable iff (!rst_n)
    mod_rsp.done |-> (state_r == S_RP || state_r == S_POS))
    else $error("remainder unit finished outside a wait state");

  a_alu_done_owned: assert property (@(posedge clk) disable iff (!rst_n)
    alu_rsp.done |-> state_r == S_MIX_ALU)
    else $error("mix unit finished outside the mix wait state");

endmodule

[tb/sv/audio_ring_mix_accumulator_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_ring_mix_accumulator_top_tb
// Self-checking bench for the audio ring mix accumulator. A short directed
// table covers the saturation corners of every sample width, the unused
// width code, ring length clamping, a pointer left beyond a shrunken ring,
// ignored register indexes and a width change between words. Random phases
// with varied widths and ring lengths follow. Every accepted word is run
// through a local model of the ring, and each read-out strobe is compared
// with the oldest predicted value.
// ----------------------------------------------------------------------------
module audio_ring_mix_accumulator_top_tb;
  import armacc_pkg::*;

  localparam logic OP_MIX = 1'b0;
  localparam logic OP_READ = 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 2'd3;
  localparam longint SAT8_HI = 127;
  localparam longint SAT8_LO = -128;
  localparam longint LIM16_HI = 32767;
  localparam longint LIM16_LO = -32768;
  localparam longint SAT16_HI = 32750;
  localparam longint SAT16_LO = -32750;
  localparam longint SAT32_HI = 64'sd2147483647;
  localparam longint SAT32_LO = -64'sd2147483648;
  localparam int SETTLE_CYCLES = 64;
  localparam int N_PHASES = 8;
  localparam int PHASE_WORDS = 178;
  localparam int TIMEOUT_NS = 5_000_000;

  typedef struct packed {
    logic is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DATA_W-1:0] data;
    logic op;
    logic [OFFSET_W-1:0] off;
    logic [SAMPLE_W-1:0] smp;
    logic fixed;
    logic [SAMPLE_W-1:0] fixed_val;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_op = 1'b0;
  logic [OFFSET_W-1:0] in_offset = '0;
  logic signed [SAMPLE_W-1:0] in_sample = '0;
  logic out_valid;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  logic [SAMPLE_W-1:0] ring_model [DEPTH];
  int rd_ptr;
  logic [1:0] width_reg;
  logic [CFG_LEN_W-1:0] len_reg;

  logic [SAMPLE_W-1:0] pending_readouts [$];
  stim_row_t directed_rows [$];
  int errors = 0;
  int n_mix = 0;
  int n_read = 0;
  int n_cfg = 0;
  int n_checked = 0;

  audio_ring_mix_accumulator_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_op(in_op),
    .in_offset(in_offset),
    .in_sample(in_sample),
    .out_valid(out_valid),
    .out_sample(out_sample),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic int ring_span();
    if (len_reg == 0) return 1;
    if (len_reg > DEPTH) return DEPTH;
    return int'(len_reg);
  endfunction

  function automatic int width_bits(logic [1:0] code);
    if (code == WCODE_8) return 8;
    if (code == WCODE_16) return 16;
    return 32;
  endfunction

  function automatic logic signed [63:0] widen(logic [SAMPLE_W-1:0] v, int bits);
    if (bits == 8) return {{56{v[7]}}, v[7:0]};
    if (bits == 16) return {{48{v[15]}}, v[15:0]};
    return {{32{v[31]}}, v};
  endfunction

  task automatic advance_ring(input logic op, input logic [OFFSET_W-1:0] off,
                              input logic [SAMPLE_W-1:0] smp, output bit has_out,
                              output logic [SAMPLE_W-1:0] readout);
    int len;
    int rp;
    int pos;
    int bits;
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic signed [63:0] c;
    len = ring_span();
    rp = rd_ptr % len;
    bits = width_bits(width_reg);
    has_out = 1'b0;
    readout = '0;
    if (op == OP_READ) begin
      c = widen(ring_model[rp], bits);
      readout = c[31:0];
      has_out = 1'b1;
      ring_model[rp] = '0;
      rd_ptr = (rp + 1) % len;
      n_read++;
    end else begin
      n_mix++;
      if (width_reg != WCODE_NONE) begin
        pos = (rp + int'(off)) % len;
        a = widen(ring_model[pos], bits);
        b = widen(smp, bits);
        c = a + b - ((a * b) >>> bits);
        case (bits)
          8: begin
            if (c > SAT8_HI) c = SAT8_HI;
            else if (c < SAT8_LO) c = SAT8_LO;
          end
          16: begin
            if (c > LIM16_HI) c = SAT16_HI;
            else if (c < LIM16_LO) c = SAT16_LO;
          end
          default: begin
            if (c > SAT32_HI) c = SAT32_HI;
            else if (c < SAT32_LO) c = SAT32_LO;
          end
        endcase
        ring_model[pos] = c[31:0];
      end
    end
  endtask

  task automatic report_mismatch(string what, logic [SAMPLE_W-1:0] got,
                                 logic [SAMPLE_W-1:0] want);
    $display("[%0t] MISMATCH %s: out_sample %h, expected %h", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (pending_readouts.size() == 0) begin
        report_mismatch("word with nothing pending", out_sample, '0);
      end else begin
        if (out_sample !== pending_readouts[0]) begin
          report_mismatch("read-out word", out_sample, pending_readouts[0]);
        end
        void'(pending_readouts.pop_front());
        n_checked++;
      end
    end
  end

  task automatic send_word(input logic op, input logic [OFFSET_W-1:0] off,
                           input logic [SAMPLE_W-1:0] smp, input logic fixed,
                           input logic [SAMPLE_W-1:0] fixed_val);
    bit has_out;
    logic [SAMPLE_W-1:0] readout;
    in_op <= op;
    in_offset <= off;
    in_sample <= smp;
    start <= 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    advance_ring(op, off, smp, has_out, readout);
    if (has_out) pending_readouts.push_back(fixed ? fixed_val : readout);
  endtask

  task automatic idle_sender(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_readouts.size() != 0) @(posedge clk);
  endtask

  task automatic settle();
    wait_results();
    while (busy !== 1'b0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_wdata <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_IDX_WIDTH) width_reg = data[1:0];
    else if (idx == CFG_IDX_LEN) len_reg = data[CFG_LEN_W-1:0];
    n_cfg++;
    @(posedge clk);
  endtask

  task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    directed_rows.push_back('{1'b1, idx, data, OP_MIX, '0, '0, 1'b0, '0});
  endtask

  task automatic add_word(input logic op, input logic [OFFSET_W-1:0] off,
                          input logic [SAMPLE_W-1:0] smp, input logic fixed,
                          input logic [SAMPLE_W-1:0] fixed_val);
    directed_rows.push_back('{1'b0, '0, '0, op, off, smp, fixed, fixed_val});
  endtask

  initial begin
    #(TIMEOUT_NS);
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    int phase;
    int i;
    int pick;
    logic op;
    logic [OFFSET_W-1:0] off;
    logic [SAMPLE_W-1:0] smp;
    logic [1:0] wsel;
    logic [CFG_LEN_W-1:0] lsel;
    bit quiet;

    foreach (ring_model[k]) ring_model[k] = '0;
    rd_ptr = 0;
    width_reg = WIDTH_RST;
    len_reg = RING_LEN_RST;

    add_word(OP_READ, 12'd0, 32'h0, 1'b1, 32'h0000_0000);
    add_word(OP_MIX, 12'd0, 32'h0000_7FFF, 1'b0, '0);
    add_word(OP_MIX, 12'd0, 32'h0000_7FFF, 1'b0, '0);
    add_word(OP_READ, 12'd0, 32'h0, 1'b1, 32'h0000_7FEE);
    add_word(OP_MIX, 12'd0, 32'hFFFF_8000, 1'b0, '0);
    add_word(OP_MIX, 12'd0, 32'hFFFF_8000, 1'b0, '0);
    add_word(OP_READ, 12'd0, 32'h0, 1'b1, 32'hFFFF_8012);
    add_word(OP_MIX, 12'd4095, 32'h1234_5678, 1'b0, '0);
    add_cfg(CFG_IDX_WIDTH, 13'(WCODE_8));
    add_word(OP_MIX, 12'd0, 32'h0000_007F, 1'b0, '0);
    add_word(OP_MIX, 12'd0, 32'h0000_007F, 1'b0, '0);
    add_word(OP_READ, 12'd0, 32'h0, 1'b1, 32'h0000_007F);
    add_word(OP_MIX, 12'd0, 32'hFFFF_FF80, 1'b0, '0);
    add_word(OP_MIX, 12'd0, 32'hFFFF_FF80, 1'b0, '0);
    add_word(OP_READ, 12'd0, 32'h0, 1'b1, 32'hFFFF_FF80);
    add_cfg(CFG_IDX_WIDTH, 13'(WCODE_32));
    add_word(OP_MIX, 12'd0, 32'h7FFF_FFFF, 1'b0, '0);
    add_word(OP_MIX, 12'd0, 32'h7FFF_FFFF, 1'b0, '0);
    add_word(OP_READ, 12'd0, 32'h0, 1'b1, 32'h7FFF_FFFF);
    add_word(OP_MIX, 12'd0, 32'h8000_0000, 1'b0, '0);
    add_word(OP_MIX, 12'd0, 32'h8000_0000, 1'b0, '0);
    add_word(OP_READ, 12'd0, 32'h0, 1'b1, 32'h8000_0000);
    add_cfg(CFG_IDX_WIDTH, 13'(WCODE_NONE));
    add_word(OP_MIX, 12'd0, 32'h5555_5555, 1'b0, '0);
    add_word(OP_READ, 12'd0, 32'h0, 1'b0, '0);
    add_cfg(CFG_IDX_LEN, 13'd3);
    add_word(OP_READ, 12'd0, 32'h0, 1'b0, '0);
    add_cfg(CFG_IDX_WIDTH, 13'(WCODE_16));
    add_cfg(CFG_IDX_LEN, 13'd0);
    add_word(OP_MIX, 12'd4095, 32'h0000_1000, 1'b0, '0);
    add_word(OP_READ, 12'd0, 32'h0, 1'b0, '0);
    add_cfg(CFG_IDX_LEN, 13'd8191);
    add_cfg(CFG_IDX_SPARE_A, 13'd0);
    add_cfg(CFG_IDX_SPARE_B, 13'd1);
    add_word(OP_MIX, 12'd0, 32'h0000_1280, 1'b0, '0);
    add_cfg(CFG_IDX_WIDTH, 13'(WCODE_8));
    add_word(OP_READ, 12'd0, 32'h0, 1'b0, '0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].is_cfg) begin
        settle();
        write_reg(directed_rows[r].idx, directed_rows[r].data);
      end else begin
        send_word(directed_rows[r].op, directed_rows[r].off, directed_rows[r].smp,
                  directed_rows[r].fixed, directed_rows[r].fixed_val);
      end
    end

    for (phase = 0; phase < N_PHASES; phase++) begin
      quiet = (phase == N_PHASES - 1);
      if (phase < 4) wsel = phase[1:0];
      else wsel = ($urandom_range(0, 9) == 0) ? WCODE_NONE : 2'($urandom_range(0, 2));
      pick = $urandom_range(0, 9);
      if (phase == 1 || pick == 8) lsel = 13'd1;
      else if (phase == 2 || pick == 7) lsel = 13'd4096;
      else if (pick == 9) lsel = 13'($urandom_range(0, 8191));
      else if (pick >= 5) lsel = 13'($urandom_range(17, 300));
      else lsel = 13'($urandom_range(2, 16));
      settle();
      if ($urandom_range(0, 1) == 0) begin
        write_reg(CFG_IDX_WIDTH, 13'(wsel));
        write_reg(CFG_IDX_LEN, lsel);
      end else begin
        write_reg(CFG_IDX_LEN, lsel);
        write_reg(CFG_IDX_WIDTH, 13'(wsel));
      end
      if ($urandom_range(0, 3) == 0) begin
        write_reg(($urandom_range(0, 1) == 0) ? CFG_IDX_SPARE_A : CFG_IDX_SPARE_B,
                  13'($urandom));
      end

      for (i = 0; i < PHASE_WORDS; i++) begin
        op = ($urandom_range(0, 9) < 4) ? OP_READ : OP_MIX;
        off = ($urandom_range(0, 1) == 0) ? 12'($urandom_range(0, 7)) : 12'($urandom);
        smp = $urandom;
        if ($urandom_range(0, 3) == 0) begin
          case ($urandom_range(0, 6))
            0: smp = 32'h7FFF_FFFF;
            1: smp = 32'h8000_0000;
            2: smp = {smp[31:16], 16'h7FFF};
            3: smp = {smp[31:16], 16'h8000};
            4: smp = {smp[31:8], 8'h7F};
            5: smp = {smp[31:8], 8'h80};
            default: smp = 32'hFFFF_FFFF;
          endcase
        end
        send_word(op, off, smp, 1'b0, '0);
        if (!quiet) begin
          if ((phase == 0 && i == PHASE_WORDS / 2) || $urandom_range(0, 79) == 0) begin
            wait_results();
          end else if ($urandom_range(0, 3) == 0) begin
            idle_sender($urandom_range(1, 9));
          end
        end
      end
    end

    settle();
    $display("Covered %0d mix words, %0d read words and %0d register writes.",
             n_mix, n_read, n_cfg);
    $display("Checked %0d read-out words over all sample widths and ring lengths 1 to 4096.",
             n_checked);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
